// ===== rtl/gqv_pkg.sv =====
// Package for the glyph quad vertex generator.
// Holds the item structs, kind and register codes, and the position saturation helper.
// No dependencies.
`default_nettype none
package gqv_pkg;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CHAR   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_SPACE_WIDTH  = 2'd3;

    localparam logic [6:0] CODE_NEWLINE = 7'd10;
    localparam logic [6:0] CODE_SPACE   = 7'd32;

    localparam logic [16:0] TEX_ONE = 17'd65536;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         code;
        logic signed [15:0] glyph_adv_x;
        logic signed [15:0] glyph_adv_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  glyph_left;
        logic signed [7:0]  glyph_top;
        logic [15:0]        glyph_offset;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        logic               is_pen_report;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        offset;
        logic signed [15:0] adv_y;
        logic signed [15:0] adv_x;
        logic signed [7:0]  top;
        logic signed [7:0]  left;
        logic [7:0]         height;
        logic [7:0]         width;
    } glyph_entry_t;

    function automatic logic signed [23:0] sat_pos(input logic signed [26:0] v);
        logic signed [23:0] r;
        if (v > 27'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -27'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/glyph_quad_vertex_generator_top.sv =====
// Top level of the glyph quad vertex generator: sequencer, shared divider, pen state.
// Depends on gqv_pkg and gqv_ram.
//
//   channel | direction | handshake              | payload
//   s_      | in        | s_valid / s_ready      | gqv_pkg::in_item_t
//   m_      | out       | m_valid / m_ready      | gqv_pkg::out_item_t
//   cfg_    | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// Load, start and newline items are handled in the idle state. A finish item passes through
// the report state and waits out any output stall. A drawn character takes one glyph table
// read, three passes of the shared restoring divider, then six vertex outputs.
// Reset is synchronous and active low; the glyph table is not cleared by it.
// A stalled output holds the vertex sequencer; the input is taken only while idle.
`default_nettype none
module glyph_quad_vertex_generator_top #(
    parameter int GLYPH_COUNT = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gqv_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gqv_pkg::out_item_t      m_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int EW = $bits(gqv_pkg::glyph_entry_t);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LOOKUP   = 3'd1;
    localparam logic [2:0] ST_DIV_INIT = 3'd2;
    localparam logic [2:0] ST_DIV_RUN  = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;
    localparam logic [2:0] ST_REPORT   = 3'd5;

    // Configuration registers.
    logic [15:0] atlas_width_reg;
    logic [7:0]  atlas_height_reg;
    logic [7:0]  line_height_reg;
    logic [15:0] space_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_width_reg  <= 16'd1;
            atlas_height_reg <= 8'd1;
            line_height_reg  <= 8'd16;
            space_width_reg  <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                gqv_pkg::CFG_ATLAS_WIDTH:  atlas_width_reg  <= cfg_data;
                gqv_pkg::CFG_ATLAS_HEIGHT: atlas_height_reg <= cfg_data[7:0];
                gqv_pkg::CFG_LINE_HEIGHT:  line_height_reg  <= cfg_data[7:0];
                gqv_pkg::CFG_SPACE_WIDTH:  space_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Glyph table: one entry holds both the shape and the motion of a code.
    logic              accept;
    logic [8:0]        code_wide;
    logic              code_in_table;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [EW-1:0]     ram_rdata;
    gqv_pkg::glyph_entry_t load_entry;
    gqv_pkg::glyph_entry_t entry;

    assign accept        = s_valid && s_ready;
    assign code_wide     = {2'b00, s_data.code};
    assign code_in_table = code_wide < 9'(GLYPH_COUNT);
    assign ram_addr      = code_wide[AW-1:0];

    always_comb begin
        load_entry.width  = s_data.glyph_width;
        load_entry.height = s_data.glyph_height;
        load_entry.left   = s_data.glyph_left;
        load_entry.top    = s_data.glyph_top;
        load_entry.adv_x  = s_data.glyph_adv_x;
        load_entry.adv_y  = s_data.glyph_adv_y;
        load_entry.offset = s_data.glyph_offset;
    end

    assign ram_we = accept && (s_data.kind == gqv_pkg::KIND_LOAD) && code_in_table;
    assign ram_re = accept && (s_data.kind == gqv_pkg::KIND_CHAR);
    assign entry  = gqv_pkg::glyph_entry_t'(ram_rdata);

    gqv_ram #(
        .WIDTH(EW),
        .DEPTH(GLYPH_COUNT)
    ) u_glyph_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (EW'(load_entry)),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Sequencer and datapath registers.
    logic [2:0]          state_reg, state_next;
    logic                hit_reg;
    logic signed [23:0]  pen_x_reg, pen_y_reg, line_x_reg;
    logic signed [26:0]  cx_reg, cy_reg, wx_reg, hy_reg;
    logic [15:0]         off_reg;
    logic [7:0]          w_reg, h_reg;
    logic signed [15:0]  adv_x_reg, adv_y_reg;
    logic [1:0]          div_sel_reg;
    logic [3:0]          div_cnt_reg;
    logic [15:0]         div_rem_reg;
    logic [15:0]         div_q_reg;
    logic [16:0]         s0_reg, s1_reg, t1_reg;
    logic [2:0]          vtx_reg;
    logic                m_valid_reg;
    gqv_pkg::out_item_t  m_data_reg;

    logic                out_free;
    logic                out_load;
    logic [16:0]         div_num;
    logic [15:0]         div_den;
    logic [16:0]         div_shift;
    logic                div_bit;
    logic [16:0]         div_quot;
    logic                vtx_right, vtx_low;
    gqv_pkg::out_item_t  vtx_item;

    assign out_free  = !m_valid_reg || m_ready;
    // The output register takes a new item in this cycle.
    assign out_load  = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_REPORT));
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Divider operands: a zero atlas size acts as one.
    always_comb begin
        case (div_sel_reg)
            2'd0: begin
                div_num = {1'b0, off_reg};
                div_den = (atlas_width_reg == 16'd0) ? 16'd1 : atlas_width_reg;
            end
            2'd1: begin
                div_num = {1'b0, off_reg} + {9'd0, w_reg};
                div_den = (atlas_width_reg == 16'd0) ? 16'd1 : atlas_width_reg;
            end
            default: begin
                div_num = {9'd0, h_reg};
                div_den = (atlas_height_reg == 8'd0) ? 16'd1 : {8'd0, atlas_height_reg};
            end
        endcase
    end

    // One restoring step: the partial remainder always stays below the divisor.
    assign div_shift = {div_rem_reg, 1'b0};
    assign div_bit   = div_shift >= {1'b0, div_den};
    assign div_quot  = {1'b0, div_q_reg[14:0], div_bit};

    // Vertex order: (L,T) (L,B) (R,T) (L,B) (R,T) (R,B).
    always_comb begin
        vtx_right = (vtx_reg == 3'd2) || (vtx_reg == 3'd4) || (vtx_reg == 3'd5);
        vtx_low   = (vtx_reg == 3'd1) || (vtx_reg == 3'd3) || (vtx_reg == 3'd5);
        vtx_item.pos_x         = gqv_pkg::sat_pos(vtx_right ? wx_reg : cx_reg);
        vtx_item.pos_y         = gqv_pkg::sat_pos(vtx_low ? hy_reg : cy_reg);
        vtx_item.tex_s         = vtx_right ? s1_reg : s0_reg;
        vtx_item.tex_t         = vtx_low ? t1_reg : 17'd0;
        vtx_item.is_pen_report = 1'b0;
        vtx_item.last          = (vtx_reg == 3'd5);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.kind)
                        gqv_pkg::KIND_FINISH: state_next = ST_REPORT;
                        gqv_pkg::KIND_CHAR: begin
                            if (s_data.code != gqv_pkg::CODE_NEWLINE) begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOKUP: begin
                // Codes past the table and empty glyphs draw nothing.
                if (!hit_reg || (entry.width == 8'd0) || (entry.height == 8'd0)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                if (div_num >= {1'b0, div_den}) begin
                    state_next = (div_sel_reg == 2'd2) ? ST_EMIT : ST_DIV_INIT;
                end else begin
                    state_next = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN: begin
                if (div_cnt_reg == 4'd15) begin
                    state_next = (div_sel_reg == 2'd2) ? ST_EMIT : ST_DIV_INIT;
                end
            end
            ST_EMIT: begin
                if (out_free && (vtx_reg == 3'd5)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            line_x_reg  <= '0;
            m_valid_reg <= 1'b0;
            div_sel_reg <= 2'd0;
            div_cnt_reg <= 4'd0;
            vtx_reg     <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        hit_reg <= code_in_table;
                        case (s_data.kind)
                            gqv_pkg::KIND_START: begin
                                pen_x_reg  <= s_data.start_x;
                                pen_y_reg  <= s_data.start_y;
                                line_x_reg <= s_data.start_x;
                            end
                            gqv_pkg::KIND_CHAR: begin
                                if (s_data.code == gqv_pkg::CODE_NEWLINE) begin
                                    pen_x_reg <= line_x_reg;
                                    pen_y_reg <= gqv_pkg::sat_pos(
                                        {{3{pen_y_reg[23]}}, pen_y_reg}
                                        - {13'd0, line_height_reg, 6'd0});
                                end else if (s_data.code == gqv_pkg::CODE_SPACE) begin
                                    pen_x_reg <= gqv_pkg::sat_pos(
                                        {{3{pen_x_reg[23]}}, pen_x_reg}
                                        + {11'd0, space_width_reg});
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    cx_reg <= {{3{pen_x_reg[23]}}, pen_x_reg}
                              + {{13{entry.left[7]}}, entry.left, 6'd0};
                    cy_reg <= {{3{pen_y_reg[23]}}, pen_y_reg}
                              + {{13{entry.top[7]}}, entry.top, 6'd0};
                    wx_reg <= {{3{pen_x_reg[23]}}, pen_x_reg}
                              + {{13{entry.left[7]}}, entry.left, 6'd0}
                              + {13'd0, entry.width, 6'd0};
                    hy_reg <= {{3{pen_y_reg[23]}}, pen_y_reg}
                              + {{13{entry.top[7]}}, entry.top, 6'd0}
                              - {13'd0, entry.height, 6'd0};
                    off_reg     <= entry.offset;
                    w_reg       <= entry.width;
                    h_reg       <= entry.height;
                    adv_x_reg   <= entry.adv_x;
                    adv_y_reg   <= entry.adv_y;
                    div_sel_reg <= 2'd0;
                end
                ST_DIV_INIT: begin
                    div_cnt_reg <= 4'd0;
                    div_q_reg   <= 16'd0;
                    if (div_num >= {1'b0, div_den}) begin
                        // A quotient of one or more saturates.
                        case (div_sel_reg)
                            2'd0:    s0_reg <= gqv_pkg::TEX_ONE;
                            2'd1:    s1_reg <= gqv_pkg::TEX_ONE;
                            default: t1_reg <= gqv_pkg::TEX_ONE;
                        endcase
                        div_sel_reg <= div_sel_reg + 2'd1;
                        vtx_reg     <= 3'd0;
                    end else begin
                        div_rem_reg <= div_num[15:0];
                    end
                end
                ST_DIV_RUN: begin
                    div_rem_reg <= div_bit ? 16'(div_shift - {1'b0, div_den})
                                           : div_shift[15:0];
                    div_q_reg   <= div_quot[15:0];
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15) begin
                        case (div_sel_reg)
                            2'd0:    s0_reg <= div_quot;
                            2'd1:    s1_reg <= div_quot;
                            default: t1_reg <= div_quot;
                        endcase
                        div_sel_reg <= div_sel_reg + 2'd1;
                        vtx_reg     <= 3'd0;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_data_reg  <= vtx_item;
                        vtx_reg     <= vtx_reg + 3'd1;
                        if (vtx_reg == 3'd5) begin
                            pen_x_reg <= gqv_pkg::sat_pos({{3{pen_x_reg[23]}}, pen_x_reg}
                                         + {{11{adv_x_reg[15]}}, adv_x_reg});
                            pen_y_reg <= gqv_pkg::sat_pos({{3{pen_y_reg[23]}}, pen_y_reg}
                                         + {{11{adv_y_reg[15]}}, adv_y_reg});
                        end
                    end
                end
                ST_REPORT: begin
                    if (out_free) begin
                        m_data_reg.pos_x         <= pen_x_reg;
                        m_data_reg.pos_y         <= pen_y_reg;
                        m_data_reg.tex_s         <= 17'd0;
                        m_data_reg.tex_t         <= 17'd0;
                        m_data_reg.is_pen_report <= 1'b1;
                        m_data_reg.last          <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The partial remainder stays below the divisor while a division runs.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_RUN) |-> ({1'b0, div_rem_reg} < {1'b0, div_den}))
        else $error("divider remainder not below divisor");

    // The vertex index never passes the sixth vertex while emitting.
    a_vtx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (vtx_reg <= 3'd5))
        else $error("vertex index out of range");

    // A new result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && ((state_reg == ST_EMIT) || (state_reg == ST_REPORT)))
        |=> $stable(m_data_reg))
        else $error("output register overwritten while stalled");

    // A pen report carries zero atlas coordinates and closes its group.
    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.is_pen_report)
        |-> (m_data_reg.last && (m_data_reg.tex_s == 17'd0) && (m_data_reg.tex_t == 17'd0)))
        else $error("malformed pen report");
`endif

endmodule
`default_nettype wire

// ===== rtl/gqv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module gqv_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
